// ----- hdl/bms_pkg.sv -----
package bms_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RADIUS      = 3'd0;
    localparam logic [2:0] CFG_WIDTH       = 3'd1;
    localparam logic [2:0] CFG_HEIGHT      = 3'd2;
    localparam logic [2:0] CFG_RESTITUTION = 3'd3;
    localparam logic [2:0] CFG_FRICTION    = 3'd4;
    localparam logic [2:0] CFG_GRAVITY     = 3'd5;
    localparam logic [2:0] CFG_GAIN        = 3'd6;

    // Register values after reset.
    localparam logic [12:0] RADIUS_RST      = 13'd160;
    localparam logic [11:0] WIDTH_RST       = 12'd800;
    localparam logic [11:0] HEIGHT_RST      = 12'd600;
    localparam logic [15:0] RESTITUTION_RST = 16'd58982;
    localparam logic [15:0] FRICTION_RST    = 16'd65208;
    localparam logic [15:0] GRAVITY_RST     = 16'd3139;
    localparam logic [15:0] GAIN_RST        = 16'd1000;

    // Item kinds.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_PLACE = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [25:0] {
        S_IDLE = 26'h0000001,
        S_FX   = 26'h0000002,
        S_FY   = 26'h0000004,
        S_GR   = 26'h0000008,
        S_GD   = 26'h0000010,
        S_PREP = 26'h0000020,
        S_AA   = 26'h0000040,
        S_BB   = 26'h0000080,
        S_SUM  = 26'h0000100,
        S_SQRT = 26'h0000200,
        S_DIV  = 26'h0000400,
        S_IX   = 26'h0000800,
        S_IY   = 26'h0001000,
        S_IY2  = 26'h0002000,
        S_VX   = 26'h0004000,
        S_VY   = 26'h0008000,
        S_PY   = 26'h0010000,
        S_WB   = 26'h0020000,
        S_WBV  = 26'h0040000,
        S_WT   = 26'h0080000,
        S_WTV  = 26'h0100000,
        S_WL   = 26'h0200000,
        S_WLV  = 26'h0400000,
        S_WR   = 26'h0800000,
        S_WRV  = 26'h1000000,
        S_DONE = 26'h2000000
    } state_t;

    // Round a Q.32 product back to Q.16, halves toward plus infinity.
    function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
        return (p + 66'sd32768) >>> 16;
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- hdl/ball_motion_step.sv -----
// One ball stepped by semi-implicit Euler integration in signed Q16.16 pixels,
// with friction, gravity, optional attraction toward a target and bouncing off
// the four arena walls. A place item goes straight to the result. A tick item
// runs longer for each wall that is hit. With attraction toward a target that is
// not on the ball it also runs a 32-step square root and two 17-step divisions,
// one step per cycle, and every product goes through a single shared 33 x 33
// multiplier. A new item is taken once the sequencer is back to idle, even while
// the previous result still waits for its transfer.
module ball_motion_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [15:0]        step_time,
    input  logic               attract_on,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic signed [15:0] place_x,
    input  logic signed [15:0] place_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_vel_x,
    output logic signed [31:0] out_vel_y
);
    import bms_pkg::*;

    // Configuration registers.
    logic [12:0] radius_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [15:0] rest_reg;
    logic [15:0] fric_reg;
    logic [15:0] grav_reg;
    logic [15:0] gain_reg;

    // Ball state and sequencer.
    state_t state_reg, state_next;
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic [15:0] dt_reg;
    logic        attr_reg;
    logic signed [15:0] tx_reg, ty_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [30:0] a_reg, b_reg;
    logic [31:0] gd_reg;
    logic [62:0] sq_reg;
    logic [63:0] n_reg, r_reg;
    logic [31:0] len_reg;
    logic [33:0] rem_reg;
    logic [16:0] q_reg, ux_reg, uy_reg;
    logic        div_y_reg;
    logic [4:0]  cnt_reg;
    logic        out_valid_reg;
    logic signed [31:0] o_px_reg, o_py_reg, o_vx_reg, o_vy_reg;

    // Shared multiplier.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    // Combinational helpers.
    logic signed [32:0] dx_new, dy_new;
    logic [32:0] mag_x, mag_y;
    logic        halve;
    logic [63:0] sq_bit, sq_try, sq_r_next;
    logic        sq_ge;
    logic        dv_ge;
    logic [33:0] dv_sub;
    logic [16:0] q_next;
    logic [25:0] diam;
    logic signed [34:0] py_ext, px_ext, hwall, wwall, y_edge, x_edge, y_lim, x_lim;
    logic signed [65:0] inc_x, inc_y;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_pos_x = o_px_reg;
    assign out_pos_y = o_py_reg;
    assign out_vel_x = o_vx_reg;
    assign out_vel_y = o_vy_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            rest_reg   <= RESTITUTION_RST;
            fric_reg   <= FRICTION_RST;
            grav_reg   <= GRAVITY_RST;
            gain_reg   <= GAIN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RADIUS:      radius_reg <= cfg_data[12:0];
                CFG_WIDTH:       width_reg  <= cfg_data[11:0];
                CFG_HEIGHT:      height_reg <= cfg_data[11:0];
                CFG_RESTITUTION: rest_reg   <= cfg_data;
                CFG_FRICTION:    fric_reg   <= cfg_data;
                CFG_GRAVITY:     grav_reg   <= cfg_data;
                CFG_GAIN:        gain_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Direction toward the target and its magnitudes, halved when too large.
    always_comb
    begin
        dx_new = {{5{tx_reg[15]}}, tx_reg, 12'b0} - 33'(pos_x_reg);
        dy_new = {{5{ty_reg[15]}}, ty_reg, 12'b0} - 33'(pos_y_reg);
        mag_x  = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        mag_y  = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        halve  = (mag_x[32:31] != 2'b00) || (mag_y[32:31] != 2'b00);
    end

    // One step of the bitwise square root.
    always_comb
    begin
        sq_bit    = 64'd1 << {cnt_reg, 1'b0};
        sq_try    = r_reg + sq_bit;
        sq_ge     = (n_reg >= sq_try);
        sq_r_next = sq_ge ? ((r_reg >> 1) + sq_bit) : (r_reg >> 1);
    end

    // One step of the restoring division.
    always_comb
    begin
        dv_ge  = (rem_reg >= {2'b0, len_reg});
        dv_sub = dv_ge ? (rem_reg - {2'b0, len_reg}) : rem_reg;
        q_next = {q_reg[15:0], dv_ge};
    end

    // Wall limits in Q16.16.
    always_comb
    begin
        diam   = {radius_reg, 13'b0};
        py_ext = 35'(pos_y_reg);
        px_ext = 35'(pos_x_reg);
        hwall  = {7'b0, height_reg, 16'b0};
        wwall  = {7'b0, width_reg, 16'b0};
        y_edge = py_ext + {9'b0, diam};
        x_edge = px_ext + {9'b0, diam};
        y_lim  = hwall - {9'b0, diam};
        x_lim  = wwall - {9'b0, diam};
    end

    // Attraction increments with the sign of the distance.
    always_comb
    begin
        inc_x = dx_reg[32] ? -rnd16(prod_reg) : rnd16(prod_reg);
        inc_y = dy_reg[32] ? -rnd16(prod_reg) : rnd16(prod_reg);
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_FX:
            begin
                mul_a = 33'(vel_x_reg);
                mul_b = {17'b0, fric_reg};
            end
            S_FY:
            begin
                mul_a = 33'(vel_y_reg);
                mul_b = {17'b0, fric_reg};
            end
            S_GR:
            begin
                mul_a = {17'b0, grav_reg};
                mul_b = {17'b0, dt_reg};
            end
            S_GD:
            begin
                mul_a = {17'b0, gain_reg};
                mul_b = {17'b0, dt_reg};
            end
            S_AA:
            begin
                mul_a = {2'b0, a_reg};
                mul_b = {2'b0, a_reg};
            end
            S_BB:
            begin
                mul_a = {2'b0, b_reg};
                mul_b = {2'b0, b_reg};
            end
            S_IX:
            begin
                mul_a = {16'b0, ux_reg};
                mul_b = {1'b0, gd_reg};
            end
            S_IY:
            begin
                mul_a = {16'b0, uy_reg};
                mul_b = {1'b0, gd_reg};
            end
            S_VX:
            begin
                mul_a = 33'(vel_x_reg);
                mul_b = {17'b0, dt_reg};
            end
            S_VY:
            begin
                mul_a = 33'(vel_y_reg);
                mul_b = {17'b0, dt_reg};
            end
            S_WB, S_WT:
            begin
                mul_a = -33'(vel_y_reg);
                mul_b = {17'b0, rest_reg};
            end
            S_WL, S_WR:
            begin
                mul_a = -33'(vel_x_reg);
                mul_b = {17'b0, rest_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = (kind == KIND_PLACE) ? S_DONE : S_FX;
            S_FX:   state_next = S_FY;
            S_FY:   state_next = S_GR;
            S_GR:   state_next = S_GD;
            S_GD:   state_next = S_PREP;
            S_PREP:
                if (attr_reg && (dx_reg != '0 || dy_reg != '0))
                    state_next = S_AA;
                else
                    state_next = S_VX;
            S_AA:   state_next = S_BB;
            S_BB:   state_next = S_SUM;
            S_SUM:  state_next = S_SQRT;
            S_SQRT:
                if (cnt_reg == 5'd0)
                    state_next = S_DIV;
            S_DIV:
                if (cnt_reg == 5'd0 && div_y_reg)
                    state_next = S_IX;
            S_IX:   state_next = S_IY;
            S_IY:   state_next = S_IY2;
            S_IY2:  state_next = S_VX;
            S_VX:   state_next = S_VY;
            S_VY:   state_next = S_PY;
            S_PY:   state_next = S_WB;
            S_WB:   state_next = (y_edge > hwall) ? S_WBV : S_WT;
            S_WBV:  state_next = S_WT;
            S_WT:   state_next = (pos_y_reg[31] || pos_y_reg == '0) ? S_WTV : S_WL;
            S_WTV:  state_next = S_WL;
            S_WL:   state_next = (pos_x_reg[31] || pos_x_reg == '0) ? S_WLV : S_WR;
            S_WLV:  state_next = S_WR;
            S_WR:   state_next = (x_edge > wwall) ? S_WRV : S_DONE;
            S_WRV:  state_next = S_DONE;
            S_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Ball state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_valid && kind == KIND_PLACE)
                    begin
                        pos_x_reg <= {{4{place_x[15]}}, place_x, 12'b0};
                        pos_y_reg <= {{4{place_y[15]}}, place_y, 12'b0};
                        vel_x_reg <= '0;
                        vel_y_reg <= '0;
                    end
                S_FY:  vel_x_reg <= sat32(rnd16(prod_reg));
                S_GR:  vel_y_reg <= sat32(rnd16(prod_reg));
                S_GD:  vel_y_reg <= sat32(66'(vel_y_reg) + (rnd16(prod_reg) >>> 4));
                S_IY:  vel_x_reg <= sat32(66'(vel_x_reg) + inc_x);
                S_IY2: vel_y_reg <= sat32(66'(vel_y_reg) + inc_y);
                S_VY:  pos_x_reg <= sat32(66'(pos_x_reg) + rnd16(prod_reg));
                S_PY:  pos_y_reg <= sat32(66'(pos_y_reg) + rnd16(prod_reg));
                S_WB:
                    if (y_edge > hwall)
                        pos_y_reg <= sat32(66'(y_lim));
                S_WT:
                    if (pos_y_reg[31] || pos_y_reg == '0)
                        pos_y_reg <= '0;
                S_WL:
                    if (pos_x_reg[31] || pos_x_reg == '0)
                        pos_x_reg <= '0;
                S_WR:
                    if (x_edge > wwall)
                        pos_x_reg <= sat32(66'(x_lim));
                S_WBV, S_WTV: vel_y_reg <= sat32(rnd16(prod_reg));
                S_WLV, S_WRV: vel_x_reg <= sat32(rnd16(prod_reg));
                default: ;
            endcase
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dt_reg   <= step_time;
                attr_reg <= attract_on;
                tx_reg   <= target_x;
                ty_reg   <= target_y;
            end
            S_GD:
            begin
                dx_reg <= dx_new;
                dy_reg <= dy_new;
            end
            S_PREP:
            begin
                gd_reg <= prod_reg[31:0];
                a_reg  <= halve ? mag_x[31:1] : mag_x[30:0];
                b_reg  <= halve ? mag_y[31:1] : mag_y[30:0];
            end
            S_BB:  sq_reg <= prod_reg[62:0];
            S_SUM:
            begin
                n_reg   <= {1'b0, sq_reg} + {1'b0, prod_reg[62:0]};
                r_reg   <= '0;
                cnt_reg <= 5'd31;
            end
            S_SQRT:
            begin
                if (sq_ge)
                    n_reg <= n_reg - sq_try;
                r_reg <= sq_r_next;
                if (cnt_reg == 5'd0)
                begin
                    len_reg   <= (sq_r_next[31:0] == '0) ? 32'd1 : sq_r_next[31:0];
                    rem_reg   <= {3'b0, a_reg};
                    q_reg     <= '0;
                    div_y_reg <= 1'b0;
                    cnt_reg   <= 5'd16;
                end
                else
                    cnt_reg <= cnt_reg - 5'd1;
            end
            S_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    if (!div_y_reg)
                    begin
                        ux_reg    <= q_next;
                        rem_reg   <= {3'b0, b_reg};
                        q_reg     <= '0;
                        div_y_reg <= 1'b1;
                        cnt_reg   <= 5'd16;
                    end
                    else
                        uy_reg <= q_next;
                end
                else
                begin
                    rem_reg <= {dv_sub[32:0], 1'b0};
                    q_reg   <= q_next;
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            default: ;
        endcase
    end

    // Result register; a finished result is held until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && (!out_valid_reg || out_ready))
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            o_px_reg <= pos_x_reg;
            o_py_reg <= pos_y_reg;
            o_vx_reg <= vel_x_reg;
            o_vy_reg <= vel_y_reg;
        end
    end

    // Checks on the sequencer.
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_place_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == KIND_PLACE) |=> (state_reg == S_DONE))
        else $error("place item did not go straight to the result");

    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == KIND_TICK) |=> (state_reg == S_FX))
        else $error("tick item did not start with friction");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (len_reg != '0))
        else $error("division started with a zero length");

    a_no_attract: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP && !attr_reg) |=> (state_reg == S_VX))
        else $error("attraction ran while disabled");

endmodule

// ----- dv/tb.sv -----
module tb;
    import bms_pkg::*;

    // Index past the end of the register list.
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // One input item and one result item.
    typedef struct {
        logic               kind;
        logic [15:0]        dt;
        logic               att;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] px;
        logic signed [15:0] py;
    } ball_item_t;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } ball_state_t;

    // A directed row; the result is typed in only where known is set.
    typedef struct {
        ball_item_t  item;
        bit          known;
        ball_state_t res;
    } motion_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic [15:0]        step_time;
    logic               attract_on;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] place_x;
    logic signed [15:0] place_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;

    ball_motion_step dut (.*);

    // Predictor copy of the registers and of the ball.
    int unsigned radius_q, width_q, height_q, rest_q, fric_q, grav_q, gain_q;
    longint      ball_px, ball_py, ball_vx, ball_vy;

    ball_state_t expected_states[$];
    motion_row_t motion_rows[$];
    int          error_count;
    int          burst_left;
    int unsigned rx_cycle;
    int unsigned rx_mode;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Round a Q.32 product to Q.16, halves toward plus infinity.
    function automatic longint round_q16(longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint damp_bounce(longint v);
        return clip32(round_q16(-v * longint'(rest_q)));
    endfunction

    // Advance the predicted ball by one item and return its new state.
    function automatic ball_state_t step_ball(ball_item_t it);
        longint dt, diam, dx, dy, ix, iy;
        longint unsigned a, b, len, ux, uy;
        ball_state_t r;
        if (it.kind == KIND_PLACE)
        begin
            ball_px = longint'(it.px) * 4096;
            ball_py = longint'(it.py) * 4096;
            ball_vx = 0;
            ball_vy = 0;
        end
        else
        begin
            dt   = longint'({48'd0, it.dt});
            diam = longint'(radius_q) * 8192;
            ball_vx = clip32(round_q16(ball_vx * longint'(fric_q)));
            ball_vy = clip32(round_q16(ball_vy * longint'(fric_q)));
            ball_vy = clip32(ball_vy + (round_q16(longint'(grav_q) * dt) >>> 4));
            // Attraction along the unit vector toward the target.
            if (it.att)
            begin
                dx = longint'(it.tx) * 4096 - ball_px;
                dy = longint'(it.ty) * 4096 - ball_py;
                if (dx != 0 || dy != 0)
                begin
                    a = (dx < 0) ? -dx : dx;
                    b = (dy < 0) ? -dy : dy;
                    if (a >= 64'h8000_0000 || b >= 64'h8000_0000)
                    begin
                        a = a >> 1;
                        b = b >> 1;
                    end
                    len = int_sqrt(a * a + b * b);
                    if (len == 0)
                        len = 1;
                    ux = (a << 16) / len;
                    uy = (b << 16) / len;
                    ix = round_q16(longint'(ux) * longint'(gain_q) * dt);
                    iy = round_q16(longint'(uy) * longint'(gain_q) * dt);
                    ball_vx = clip32(ball_vx + ((dx < 0) ? -ix : ix));
                    ball_vy = clip32(ball_vy + ((dy < 0) ? -iy : iy));
                end
            end
            ball_px = clip32(ball_px + round_q16(ball_vx * dt));
            ball_py = clip32(ball_py + round_q16(ball_vy * dt));
            // Walls in order: bottom, top, left, right.
            if (ball_py + diam > longint'(height_q) * 65536)
            begin
                ball_py = clip32(longint'(height_q) * 65536 - diam);
                ball_vy = damp_bounce(ball_vy);
            end
            if (ball_py <= 0)
            begin
                ball_py = 0;
                ball_vy = damp_bounce(ball_vy);
            end
            if (ball_px <= 0)
            begin
                ball_px = 0;
                ball_vx = damp_bounce(ball_vx);
            end
            if (ball_px + diam > longint'(width_q) * 65536)
            begin
                ball_px = clip32(longint'(width_q) * 65536 - diam);
                ball_vx = damp_bounce(ball_vx);
            end
        end
        r.pos_x = ball_px[31:0];
        r.pos_y = ball_py[31:0];
        r.vel_x = ball_vx[31:0];
        r.vel_y = ball_vy[31:0];
        return r;
    endfunction

    function automatic ball_item_t make_item(logic k, logic [15:0] dt, logic att,
                                             logic [15:0] tx, logic [15:0] ty,
                                             logic [15:0] px, logic [15:0] py);
        ball_item_t it;
        it.kind = k;
        it.dt   = dt;
        it.att  = att;
        it.tx   = tx;
        it.ty   = ty;
        it.px   = px;
        it.py   = py;
        return it;
    endfunction

    function automatic void add_row(ball_item_t it, bit known,
                                    logic [31:0] p0, logic [31:0] p1);
        motion_row_t row;
        row.item      = it;
        row.known     = known;
        row.res.pos_x = p0;
        row.res.pos_y = p1;
        row.res.vel_x = '0;
        row.res.vel_y = '0;
        motion_rows.push_back(row);
    endfunction

    // Send one item in bursts with random gaps, then predict on its transfer.
    task automatic send_ball(ball_item_t it, bit known, ball_state_t typed);
        ball_state_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        kind       <= it.kind;
        step_time  <= it.dt;
        attract_on <= it.att;
        target_x   <= it.tx;
        target_y   <= it.ty;
        place_x    <= it.px;
        place_y    <= it.py;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = step_ball(it);
        expected_states.push_back(known ? typed : r);
        burst_left--;
    endtask

    // Wait until every expected result has arrived and the block is idle.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_states.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIUS:      radius_q = 32'(val[12:0]);
            CFG_WIDTH:       width_q  = 32'(val[11:0]);
            CFG_HEIGHT:      height_q = 32'(val[11:0]);
            CFG_RESTITUTION: rest_q   = 32'(val);
            CFG_FRICTION:    fric_q   = 32'(val);
            CFG_GRAVITY:     grav_q   = 32'(val);
            CFG_GAIN:        gain_q   = 32'(val);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_arena(logic [15:0] r, logic [15:0] w, logic [15:0] h,
                              logic [15:0] e, logic [15:0] f, logic [15:0] g,
                              logic [15:0] k);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_RESTITUTION, e);
        write_reg(CFG_FRICTION, f);
        write_reg(CFG_GRAVITY, g);
        write_reg(CFG_GAIN, k);
    endtask

    // Random items: mostly ticks, targets often inside the arena.
    task automatic run_random(int count);
        ball_item_t  it;
        ball_state_t none;
        none = '{default: '0};
        repeat (count)
        begin
            it.kind = ($urandom_range(0, 9) == 0) ? KIND_PLACE : KIND_TICK;
            case ($urandom_range(0, 3))
                0: it.dt = 16'($urandom);
                1: it.dt = 16'($urandom_range(0, 16));
                default: it.dt = 16'($urandom_range(200, 3000));
            endcase
            it.att = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 2) == 0)
            begin
                it.tx = 16'($urandom);
                it.ty = 16'($urandom);
            end
            else
            begin
                it.tx = 16'($urandom_range(0, width_q * 16 + 16));
                it.ty = 16'($urandom_range(0, height_q * 16 + 16));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                it.px = 16'($urandom);
                it.py = 16'($urandom);
            end
            else
            begin
                it.px = 16'($urandom_range(0, width_q * 16));
                it.py = 16'($urandom_range(0, height_q * 16));
            end
            send_ball(it, 1'b0, none);
        end
        drain();
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, $signed(want), $signed(got));
            error_count++;
        end
    endtask

    // Receiver: picks at random a stall pattern (always ready, random, or sparse); check each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cycle  <= 0;
            rx_mode   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_states.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected", $time);
                    error_count++;
                end
                else
                begin
                    check_field("pos_x", expected_states[0].pos_x, out_pos_x);
                    check_field("pos_y", expected_states[0].pos_y, out_pos_y);
                    check_field("vel_x", expected_states[0].vel_x, out_vel_x);
                    check_field("vel_y", expected_states[0].vel_y, out_vel_y);
                    void'(expected_states.pop_front());
                end
            end
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 200 == 0)
                rx_mode <= $urandom_range(0, 2);
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= (rx_cycle % 5 == 0);
            endcase
        end
    end

    // Stimulus.
    initial
    begin
        ball_state_t typed;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        kind       = KIND_TICK;
        step_time  = '0;
        attract_on = 1'b0;
        target_x   = '0;
        target_y   = '0;
        place_x    = '0;
        place_y    = '0;
        error_count = 0;
        burst_left  = 0;
        radius_q = 32'(RADIUS_RST);
        width_q  = 32'(WIDTH_RST);
        height_q = 32'(HEIGHT_RST);
        rest_q   = 32'(RESTITUTION_RST);
        fric_q   = 32'(FRICTION_RST);
        grav_q   = 32'(GRAVITY_RST);
        gain_q   = 32'(GAIN_RST);
        ball_px = 0;
        ball_py = 0;
        ball_vx = 0;
        ball_vy = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings.
        add_row(make_item(KIND_TICK, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0),
                1'b1, '0, '0);
        add_row(make_item(KIND_PLACE, 16'hffff, 1'b1, 16'h7fff, 16'h8000, 16'd1600,
                          16'd800), 1'b1, 32'd6553600, 32'd3276800);
        add_row(make_item(KIND_TICK, 16'hffff, 1'b0, 16'h7fff, 16'h7fff, 16'h8000,
                          16'h7fff), 1'b0, '0, '0);
        add_row(make_item(KIND_TICK, 16'd6554, 1'b1, 16'h7fff, 16'h7fff, 16'd0, 16'd0),
                1'b0, '0, '0);
        add_row(make_item(KIND_PLACE, 16'd0, 1'b0, 16'd0, 16'd0, 16'h8000, 16'h7fff),
                1'b1, -32'sd134217728, 32'd134213632);
        // Zero distance: target sits exactly on the ball.
        add_row(make_item(KIND_TICK, 16'd0, 1'b1, 16'h8000, 16'h7fff, 16'd0, 16'd0),
                1'b0, '0, '0);
        add_row(make_item(KIND_PLACE, 16'd0, 1'b0, 16'd0, 16'd0, 16'd3200, 16'd3200),
                1'b1, 32'd13107200, 32'd13107200);
        add_row(make_item(KIND_TICK, 16'd3277, 1'b1, 16'd3200, 16'd3200, 16'd0, 16'd0),
                1'b0, '0, '0);
        add_row(make_item(KIND_TICK, 16'hffff, 1'b1, 16'd0, 16'd0, 16'd5, 16'd5),
                1'b0, '0, '0);
        add_row(make_item(KIND_TICK, 16'd1, 1'b1, 16'h8000, 16'h8000, 16'd0, 16'd0),
                1'b0, '0, '0);
        add_row(make_item(KIND_PLACE, 16'h1234, 1'b1, 16'h5555, 16'haaaa, 16'd0, 16'd0),
                1'b1, '0, '0);
        add_row(make_item(KIND_PLACE, 16'd0, 1'b0, 16'd0, 16'd0, 16'd16, 16'hfff0),
                1'b1, 32'd65536, -32'sd65536);
        add_row(make_item(KIND_TICK, 16'd1000, 1'b1, 16'd12800, 16'd9600, 16'haaaa,
                          16'h5555), 1'b0, '0, '0);
        add_row(make_item(KIND_TICK, 16'h8000, 1'b0, 16'h8000, 16'h8000, 16'd0, 16'd0),
                1'b0, '0, '0);
        add_row(make_item(KIND_TICK, 16'h7fff, 1'b1, 16'h7fff, 16'd0, 16'd0, 16'd0),
                1'b0, '0, '0);
        foreach (motion_rows[i])
        begin
            typed = motion_rows[i].res;
            send_ball(motion_rows[i].item, motion_rows[i].known, typed);
        end
        drain();

        run_random(100);
        // Reset values again, with junk in the unused high bits.
        load_arena(16'he0a0, 16'hf320, 16'hf258, 16'd58982, 16'd65208, 16'd3139, 16'd1000);
        write_reg(CFG_UNUSED, 16'hbeef);
        run_random(140);
        // Largest settings: velocities saturate.
        load_arena(16'h1fff, 16'hfff, 16'hfff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        run_random(120);
        // Smallest settings.
        load_arena(16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(100);
        // Ball wider than the arena: both walls of an axis fire.
        load_arena(16'd6400, 16'($urandom_range(1, 60)), 16'($urandom_range(1, 60)),
                   16'd50000, 16'd65535, 16'd3139, 16'd2000);
        run_random(120);
        repeat (3)
        begin
            load_arena(16'($urandom_range(0, 8191)), 16'($urandom_range(1, 4095)),
                       16'($urandom_range(1, 4095)), 16'($urandom),
                       16'($urandom_range(60000, 65535)),
                       16'($urandom), 16'($urandom_range(0, 5000)));
            run_random(110);
        end

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
